// ----- rtl/sdc_pkg.sv -----
`default_nettype none

package sdc_pkg;

    localparam int SERIAL_BITS = 17;
    localparam int COUNT_BITS  = 10;
    localparam int YEAR_W      = 12;

    // The serial register has two guard bits so that overflow past the top serial stays visible.
    localparam int SER_W = SERIAL_BITS + 2;
    localparam int ALU_W = SER_W + 1;

    localparam int NDIG      = (SERIAL_BITS + 2) / 3;
    localparam int DIG_W     = NDIG * 3;
    localparam int DIG_CNT_W = $clog2(NDIG + 1);

    localparam int BASE_YEAR = 1900;
    localparam int YEAR_DAYS = 365;

    localparam logic [1:0] C4_INIT   = 2'(BASE_YEAR % 4);
    localparam logic [6:0] C100_INIT = 7'(BASE_YEAR % 100);
    localparam logic [1:0] CENT_INIT = 2'((BASE_YEAR / 100) % 4);

    typedef logic [1:0]       t_cmd;
    typedef logic [DIG_W-1:0] t_digits;

    localparam t_cmd CMD_TO_DATE   = 2'd0;
    localparam t_cmd CMD_TO_SERIAL = 2'd1;
    localparam t_cmd CMD_ADD_BDAYS = 2'd2;
    localparam t_cmd CMD_ROLL      = 2'd3;

    localparam logic [2:0] WD_MON = 3'd1;
    localparam logic [2:0] WD_FRI = 3'd5;
    localparam logic [2:0] WD_SAT = 3'd6;
    localparam logic [2:0] WD_SUN = 3'd7;

    localparam logic [3:0] MON_JAN = 4'd1;
    localparam logic [3:0] MON_FEB = 4'd2;
    localparam logic [3:0] MON_DEC = 4'd12;

    localparam logic [4:0] MONTH_LEN [16] = '{
        5'd0, 5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31,
        5'd31, 5'd30, 5'd31, 5'd30, 5'd31, 5'd0, 5'd0, 5'd0
    };

    typedef struct packed {
        logic init;
        logic step;
    } t_year_ctl;

    typedef struct packed {
        logic       busy;
        logic [2:0] wday;
    } t_wday_stat;

    function automatic logic [4:0] month_days(input logic [3:0] m, input logic leap);
        logic [4:0] len;
        len = MONTH_LEN[m];
        if (leap && m == MON_FEB) begin
            len = 5'd29;
        end
        return len;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/serial_date_calendar_unit.sv -----
`default_nettype none

// Calendar unit on day serials (serial 1 is Monday 1 January 1900, Gregorian leap years).
// Input channel: i_in_valid with the command and operand ports; a beat is taken when
// i_in_valid is high and o_in_stall is low. o_in_stall stays high from the accepted beat
// until the result beat has been taken, so one item is in flight at a time.
// Output channel: o_out_valid with the result ports; the beat is taken when o_out_valid is
// high and i_out_stall is low. While i_out_stall is high the result holds unchanged.
// Sequence: every command runs a weekday pass and ends with a date decomposition that
// walks the years after 1900 one at a time and then the months from January. Date to
// serial first adds the same year and month walk to build the serial. Add business days
// steps one calendar day at a time, and roll to business day steps forward over a weekend.
// The year, month and day walks run on one shared adder and a one-year-per-cycle counter;
// the weekday pass sums its digits with its own adder in sdc_mod7.
// Reset (synchronous, active low) returns the sequencer to idle with no result pending.

module serial_date_calendar_unit (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_in_valid,
    output logic                                   o_in_stall,
    input  wire logic [1:0]                        i_command,
    input  wire logic [sdc_pkg::SERIAL_BITS-1:0]   i_serial_in,
    input  wire logic [4:0]                        i_day_in,
    input  wire logic [3:0]                        i_month_in,
    input  wire logic [sdc_pkg::YEAR_W-1:0]        i_year_in,
    input  wire logic [sdc_pkg::COUNT_BITS-1:0]    i_count,
    output logic                                   o_out_valid,
    input  wire logic                              i_out_stall,
    output logic [sdc_pkg::SERIAL_BITS-1:0]        o_serial_out,
    output logic [4:0]                             o_day_out,
    output logic [3:0]                             o_month_out,
    output logic [sdc_pkg::YEAR_W-1:0]             o_year_out,
    output logic [2:0]                             o_day_of_week,
    output logic                                   o_business_day,
    output logic                                   o_error
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_Y2S,
        S_M2S,
        S_S2FIN,
        S_WSTART,
        S_WWAIT,
        S_STEP,
        S_DINIT,
        S_YOF,
        S_MOF,
        S_DONE
    } t_state;

    t_state r_state, n_state;

    sdc_pkg::t_cmd                 r_cmd, n_cmd;
    logic [4:0]                    r_d_in, n_d_in;
    logic [3:0]                    r_m_in, n_m_in;
    logic [sdc_pkg::YEAR_W-1:0]    r_y_in, n_y_in;
    logic [sdc_pkg::COUNT_BITS-1:0] r_cnt, n_cnt;
    logic [sdc_pkg::SER_W-1:0]     r_ser, n_ser;
    logic [sdc_pkg::SER_W-1:0]     r_rem, n_rem;
    logic [3:0]                    r_mon, n_mon;
    logic [4:0]                    r_day, n_day;
    logic [2:0]                    r_wd, n_wd;
    logic                          r_err, n_err;
    logic                          r_pre, n_pre;

    sdc_pkg::t_year_ctl            year_ctl;
    sdc_pkg::t_wday_stat           wd_stat;
    logic                          wd_start;
    logic [sdc_pkg::YEAR_W-1:0]    year;
    logic                          leap;

    logic [8:0]                    year_len;
    logic [4:0]                    dom;
    logic                          over;
    logic                          weekend;
    logic [2:0]                    wd_next;
    logic                          in_bad;

    logic [sdc_pkg::ALU_W-1:0]     alu_a, alu_b, alu_res;
    logic                          alu_sub;
    logic                          borrow;

    sdc_year u_year (
        .i_clk  (i_clk),
        .i_ctl  (year_ctl),
        .o_year (year),
        .o_leap (leap)
    );

    sdc_mod7 u_mod7 (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (wd_start),
        .i_serial (r_ser[sdc_pkg::SERIAL_BITS-1:0]),
        .o_stat   (wd_stat)
    );

    assign year_len = leap ? 9'(sdc_pkg::YEAR_DAYS + 1) : 9'(sdc_pkg::YEAR_DAYS);
    assign dom      = sdc_pkg::month_days(r_mon, leap);
    assign over     = (r_ser[sdc_pkg::SER_W-1:sdc_pkg::SERIAL_BITS] != '0);
    assign weekend  = (r_wd >= sdc_pkg::WD_SAT);
    assign wd_next  = (r_wd == sdc_pkg::WD_SUN) ? sdc_pkg::WD_MON : r_wd + 1'b1;
    assign in_bad   = (i_year_in < sdc_pkg::YEAR_W'(sdc_pkg::BASE_YEAR))
                   || (i_month_in == 4'd0) || (i_month_in > sdc_pkg::MON_DEC)
                   || (i_day_in == 5'd0);

    // The one adder shared by every loop of the sequencer.
    always_comb begin
        alu_a   = sdc_pkg::ALU_W'(r_ser);
        alu_b   = '0;
        alu_sub = 1'b0;
        case (r_state)
            S_Y2S: begin
                alu_b = sdc_pkg::ALU_W'(year_len);
            end
            S_M2S: begin
                alu_b = (r_mon == r_m_in) ? sdc_pkg::ALU_W'(r_d_in) : sdc_pkg::ALU_W'(dom);
            end
            S_STEP: begin
                alu_b = sdc_pkg::ALU_W'(1);
            end
            S_DINIT: begin
                alu_b   = sdc_pkg::ALU_W'(1);
                alu_sub = 1'b1;
            end
            S_YOF: begin
                alu_a   = sdc_pkg::ALU_W'(r_rem);
                alu_b   = sdc_pkg::ALU_W'(year_len);
                alu_sub = 1'b1;
            end
            S_MOF: begin
                alu_a   = sdc_pkg::ALU_W'(r_rem);
                alu_b   = sdc_pkg::ALU_W'(dom);
                alu_sub = 1'b1;
            end
            default: begin
                alu_b = '0;
            end
        endcase
    end

    assign alu_res = alu_sub ? (alu_a - alu_b) : (alu_a + alu_b);
    assign borrow  = alu_res[sdc_pkg::ALU_W-1];

    always_comb begin
        n_state  = r_state;
        n_cmd    = r_cmd;
        n_d_in   = r_d_in;
        n_m_in   = r_m_in;
        n_y_in   = r_y_in;
        n_cnt    = r_cnt;
        n_ser    = r_ser;
        n_rem    = r_rem;
        n_mon    = r_mon;
        n_day    = r_day;
        n_wd     = r_wd;
        n_err    = r_err;
        n_pre    = r_pre;
        year_ctl = '0;
        wd_start = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_cmd  = i_command;
                    n_d_in = i_day_in;
                    n_m_in = i_month_in;
                    n_y_in = i_year_in;
                    n_cnt  = i_count;
                    n_err  = 1'b0;
                    n_ser  = sdc_pkg::SER_W'(i_serial_in);
                    n_pre  = (i_command == sdc_pkg::CMD_ADD_BDAYS)
                          || (i_command == sdc_pkg::CMD_ROLL);
                    n_state = S_WSTART;
                    if (i_command == sdc_pkg::CMD_TO_SERIAL) begin
                        year_ctl.init = 1'b1;
                        n_ser = '0;
                        n_mon = sdc_pkg::MON_JAN;
                        if (in_bad) begin
                            n_err = 1'b1;
                        end else begin
                            n_state = S_Y2S;
                        end
                    end
                end
            end
            S_Y2S: begin
                if (year == r_y_in) begin
                    n_state = S_M2S;
                end else if (over) begin
                    // Once past the top serial the date can only land further out.
                    n_err   = 1'b1;
                    n_ser   = '0;
                    n_state = S_WSTART;
                end else begin
                    n_ser         = alu_res[sdc_pkg::SER_W-1:0];
                    year_ctl.step = 1'b1;
                end
            end
            S_M2S: begin
                if (r_mon == r_m_in) begin
                    if (r_d_in > dom) begin
                        n_err   = 1'b1;
                        n_ser   = '0;
                        n_state = S_WSTART;
                    end else begin
                        n_ser   = alu_res[sdc_pkg::SER_W-1:0];
                        n_state = S_S2FIN;
                    end
                end else begin
                    n_ser = alu_res[sdc_pkg::SER_W-1:0];
                    n_mon = r_mon + 1'b1;
                end
            end
            S_S2FIN: begin
                if (over) begin
                    n_err = 1'b1;
                    n_ser = '0;
                end
                n_state = S_WSTART;
            end
            S_WSTART: begin
                wd_start = 1'b1;
                n_state  = S_WWAIT;
            end
            S_WWAIT: begin
                if (!wd_stat.busy) begin
                    n_wd = wd_stat.wday;
                    if (r_pre) begin
                        n_pre   = 1'b0;
                        n_state = S_STEP;
                    end else begin
                        n_state = S_DINIT;
                    end
                end
            end
            S_STEP: begin
                // Every step moves one calendar day; only a weekday step uses up the count.
                if ((r_cmd == sdc_pkg::CMD_ROLL) ? weekend : (r_cnt != '0)) begin
                    n_ser = alu_res[sdc_pkg::SER_W-1:0];
                    n_wd  = wd_next;
                    if (r_cmd == sdc_pkg::CMD_ADD_BDAYS && !weekend) begin
                        n_cnt = r_cnt - 1'b1;
                    end
                end else begin
                    if (over) begin
                        n_err = 1'b1;
                        n_ser = '0;
                        n_wd  = sdc_pkg::WD_SUN;
                    end
                    n_state = S_DINIT;
                end
            end
            S_DINIT: begin
                year_ctl.init = 1'b1;
                n_mon         = sdc_pkg::MON_JAN;
                if (r_ser == '0) begin
                    n_day   = 5'd0;
                    n_state = S_DONE;
                end else begin
                    n_rem   = alu_res[sdc_pkg::SER_W-1:0];
                    n_state = S_YOF;
                end
            end
            S_YOF: begin
                if (borrow) begin
                    n_state = S_MOF;
                end else begin
                    n_rem         = alu_res[sdc_pkg::SER_W-1:0];
                    year_ctl.step = 1'b1;
                end
            end
            S_MOF: begin
                if (r_mon != sdc_pkg::MON_DEC && !borrow) begin
                    n_rem = alu_res[sdc_pkg::SER_W-1:0];
                    n_mon = r_mon + 1'b1;
                end else begin
                    n_day   = r_rem[4:0] + 5'd1;
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (!i_out_stall) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
            r_cmd   <= n_cmd;
            r_d_in  <= n_d_in;
            r_m_in  <= n_m_in;
            r_y_in  <= n_y_in;
            r_cnt   <= n_cnt;
            r_ser   <= n_ser;
            r_rem   <= n_rem;
            r_mon   <= n_mon;
            r_day   <= n_day;
            r_wd    <= n_wd;
            r_err   <= n_err;
            r_pre   <= n_pre;
        end
    end

    assign o_in_stall     = (r_state != S_IDLE);
    assign o_out_valid    = (r_state == S_DONE);
    assign o_serial_out   = r_ser[sdc_pkg::SERIAL_BITS-1:0];
    assign o_day_out      = r_day;
    assign o_month_out    = r_mon;
    assign o_year_out     = year;
    assign o_day_of_week  = r_wd;
    assign o_business_day = (r_wd <= sdc_pkg::WD_FRI);
    assign o_error        = r_err;

endmodule

`default_nettype wire

// ----- rtl/sdc_year.sv -----
`default_nettype none

module sdc_year (
    input  wire logic                    i_clk,
    input  wire sdc_pkg::t_year_ctl      i_ctl,
    output logic [sdc_pkg::YEAR_W-1:0]   o_year,
    output logic                         o_leap
);

    logic [sdc_pkg::YEAR_W-1:0] r_year;
    logic [1:0]                 r_c4;
    logic [6:0]                 r_c100;
    logic [1:0]                 r_cent;

    // Position within the four-year, century and four-century cycles, so the leap rule
    // needs no division.
    always_ff @(posedge i_clk) begin
        if (i_ctl.init) begin
            r_year <= sdc_pkg::YEAR_W'(sdc_pkg::BASE_YEAR);
            r_c4   <= sdc_pkg::C4_INIT;
            r_c100 <= sdc_pkg::C100_INIT;
            r_cent <= sdc_pkg::CENT_INIT;
        end else if (i_ctl.step) begin
            r_year <= r_year + 1'b1;
            r_c4   <= r_c4 + 1'b1;
            if (r_c100 == 7'd99) begin
                r_c100 <= 7'd0;
                r_cent <= r_cent + 1'b1;
            end else begin
                r_c100 <= r_c100 + 1'b1;
            end
        end
    end

    assign o_year = r_year;
    assign o_leap = (r_c4 == 2'd0) && ((r_c100 != 7'd0) || (r_cent == 2'd0));

endmodule

`default_nettype wire

// ----- rtl/sdc_mod7.sv -----
`default_nettype none

module sdc_mod7 (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_start,
    input  wire logic [sdc_pkg::SERIAL_BITS-1:0] i_serial,
    output sdc_pkg::t_wday_stat                 o_stat
);

    logic [sdc_pkg::DIG_CNT_W-1:0] r_left;
    sdc_pkg::t_digits              r_dig;
    logic [2:0]                    r_acc;
    logic [3:0]                    sum;

    // Eight is one modulo seven, so the octal digits are summed modulo seven.
    assign sum = {1'b0, r_acc} + {1'b0, r_dig[2:0]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left <= '0;
        end else if (i_start) begin
            r_left <= sdc_pkg::DIG_CNT_W'(sdc_pkg::NDIG);
            r_dig  <= sdc_pkg::t_digits'(i_serial);
            r_acc  <= 3'd0;
        end else if (r_left != '0) begin
            r_left <= r_left - 1'b1;
            r_dig  <= r_dig >> 3;
            r_acc  <= (sum >= 4'd7) ? 3'(sum - 4'd7) : sum[2:0];
        end
    end

    // Serial plus six modulo seven, plus one, comes out as the remainder itself with
    // zero standing for Sunday.
    assign o_stat.busy = (r_left != '0);
    assign o_stat.wday = (r_acc == 3'd0) ? sdc_pkg::WD_SUN : r_acc;

endmodule

`default_nettype wire
